// ===== hw/rtl/mct_pkg.sv =====
package mct_pkg;

    localparam int SYMBOL_W        = 8;
    localparam int CHAR_W          = 8;
    localparam int PAT_W           = 5;
    localparam int LEN_W           = 3;
    localparam int STEP_W          = 3;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CODE_COUNT      = 36;

    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    localparam logic [LEN_W-1:0] LEN_MAX      = 3'd5;
    localparam logic [LEN_W-1:0] LEN_TOO_LONG = 3'd6;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // dash = 1, first symbol in bit len-1
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [PAT_W-1:0]  pat;
    } code_entry_t;

    // one queued job: optional bar, then n_sym symbols, then the tail char
    typedef struct packed {
        logic              pre_bar;
        logic [LEN_W-1:0]  n_sym;
        logic [PAT_W-1:0]  pat;
        logic [CHAR_W-1:0] tail;
    } job_t;

    localparam code_entry_t CODE_TABLE [CODE_COUNT] = '{
        '{8'h41, 3'd2, 5'b00001}, '{8'h42, 3'd4, 5'b01000}, '{8'h43, 3'd4, 5'b01010},
        '{8'h44, 3'd3, 5'b00100}, '{8'h45, 3'd1, 5'b00000}, '{8'h46, 3'd4, 5'b00010},
        '{8'h47, 3'd3, 5'b00110}, '{8'h48, 3'd4, 5'b00000}, '{8'h49, 3'd2, 5'b00000},
        '{8'h4A, 3'd4, 5'b00111}, '{8'h4B, 3'd3, 5'b00101}, '{8'h4C, 3'd4, 5'b00100},
        '{8'h4D, 3'd2, 5'b00011}, '{8'h4E, 3'd2, 5'b00010}, '{8'h4F, 3'd3, 5'b00111},
        '{8'h50, 3'd4, 5'b00110}, '{8'h51, 3'd4, 5'b01101}, '{8'h52, 3'd3, 5'b00010},
        '{8'h53, 3'd3, 5'b00000}, '{8'h54, 3'd1, 5'b00001}, '{8'h55, 3'd3, 5'b00001},
        '{8'h56, 3'd4, 5'b00001}, '{8'h57, 3'd3, 5'b00011}, '{8'h58, 3'd4, 5'b01001},
        '{8'h59, 3'd4, 5'b01011}, '{8'h5A, 3'd4, 5'b01100},
        '{8'h30, 3'd5, 5'b11111}, '{8'h31, 3'd5, 5'b01111}, '{8'h32, 3'd5, 5'b00111},
        '{8'h33, 3'd5, 5'b00011}, '{8'h34, 3'd5, 5'b00001}, '{8'h35, 3'd5, 5'b00000},
        '{8'h36, 3'd5, 5'b10000}, '{8'h37, 3'd5, 5'b11000}, '{8'h38, 3'd5, 5'b11100},
        '{8'h39, 3'd5, 5'b11110}
    };

    // len = 0 when the character has no code
    function automatic code_entry_t encode_lookup(input logic [CHAR_W-1:0] ch);
        code_entry_t r;
        r = '{ch: CH_NONE, len: '0, pat: '0};
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (CODE_TABLE[i].ch == ch) begin
                r = CODE_TABLE[i];
            end
        end
        return r;
    endfunction

    // CH_NONE when no character has this code
    function automatic logic [CHAR_W-1:0] decode_lookup(input logic [LEN_W-1:0] len,
                                                        input logic [PAT_W-1:0] pat);
        logic [CHAR_W-1:0] r;
        r = CH_NONE;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (CODE_TABLE[i].len == len && CODE_TABLE[i].pat == pat) begin
                r = CODE_TABLE[i].ch;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mct_in_if.sv =====
interface mct_in_if;
    import mct_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                line_end;

    modport source (output valid, output symbol, output line_end, input ready);
    modport sink   (input valid, input symbol, input line_end, output ready);
endinterface

// ===== hw/rtl/mct_out_if.sv =====
interface mct_out_if;
    import mct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ===== hw/rtl/mct_front.sv =====
module mct_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_data,
    mct_in_if.sink        item,
    input  logic          q_full,
    output logic          push,
    output mct_pkg::job_t push_job
);
    import mct_pkg::*;

    logic             direction_reg;
    logic [PAT_W-1:0] pattern_reg,   pattern_next;
    logic [LEN_W-1:0] length_reg,    length_next;
    logic             malformed_reg, malformed_next;
    logic             is_bar_reg,    is_bar_next;

    logic              accept;
    code_entry_t       enc;
    logic [CHAR_W-1:0] dec;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign enc        = encode_lookup(item.symbol);
    assign dec        = decode_lookup(length_reg, pattern_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            pattern_reg   <= '0;
            length_reg    <= '0;
            malformed_reg <= 1'b0;
            is_bar_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_data;
            end
            pattern_reg   <= pattern_next;
            length_reg    <= length_next;
            malformed_reg <= malformed_next;
            is_bar_reg    <= is_bar_next;
        end
    end

    always_comb
    begin
        pattern_next   = pattern_reg;
        length_next    = length_reg;
        malformed_next = malformed_reg;
        is_bar_next    = is_bar_reg;
        push           = 1'b0;
        push_job       = '{pre_bar: 1'b0, n_sym: '0, pat: '0, tail: CH_SPACE};
        if (accept)
        begin
            if (direction_reg == DIR_ENCODE)
            begin
                if (item.line_end)
                begin
                    pattern_next   = '0;
                    length_next    = '0;
                    malformed_next = 1'b0;
                    is_bar_next    = 1'b0;
                end
                else
                begin
                    push = 1'b1;
                    if (item.symbol == CH_SPACE)
                    begin
                        push_job.pre_bar = 1'b1;
                    end
                    else
                    begin
                        push_job.n_sym = enc.len;
                        push_job.pat   = enc.pat;
                    end
                end
            end
            else if (item.line_end || item.symbol == CH_SPACE)
            begin
                // token closes
                pattern_next   = '0;
                length_next    = '0;
                malformed_next = 1'b0;
                is_bar_next    = 1'b0;
                if (!malformed_reg)
                begin
                    if (is_bar_reg)
                    begin
                        push = 1'b1;
                    end
                    else if (length_reg >= 3'd1 && length_reg <= LEN_MAX && dec != CH_NONE)
                    begin
                        push          = 1'b1;
                        push_job.tail = dec;
                    end
                end
            end
            else if (item.symbol == CH_BAR)
            begin
                if (length_reg == '0 && !malformed_reg && !is_bar_reg)
                begin
                    is_bar_next = 1'b1;
                end
                else
                begin
                    malformed_next = 1'b1;
                    is_bar_next    = 1'b0;
                end
            end
            else if (item.symbol == CH_DOT || item.symbol == CH_DASH)
            begin
                if (is_bar_reg)
                begin
                    malformed_next = 1'b1;
                    is_bar_next    = 1'b0;
                end
                if (length_reg < LEN_MAX)
                begin
                    pattern_next = {pattern_reg[PAT_W-2:0], item.symbol == CH_DASH};
                    length_next  = length_reg + 3'd1;
                end
                else
                begin
                    length_next = LEN_TOO_LONG;
                end
            end
            else
            begin
                malformed_next = 1'b1;
                is_bar_next    = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/mct_queue.sv =====
module mct_queue #(
    parameter int DEPTH = mct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mct_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mct_pkg::job_t head_job
);
    import mct_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/mct_back.sv =====
module mct_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mct_pkg::job_t head_job,
    output logic          pop,
    mct_out_if.source     result
);
    import mct_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg,  out_char_next;
    logic              out_last_reg,  out_last_next;
    logic [STEP_W-1:0] step_reg,      step_next;

    logic              load;
    logic              bar_phase;
    logic              sym_phase;
    logic [STEP_W-1:0] sym_k;
    logic [LEN_W-1:0]  bit_idx;
    logic [CHAR_W-1:0] cur_char;

    assign result.valid    = out_valid_reg;
    assign result.out_char = out_char_reg;
    assign result.last     = out_last_reg;

    assign load      = !out_valid_reg || result.ready;
    assign bar_phase = head_job.pre_bar && (step_reg == '0);
    assign sym_k     = step_reg - {{(STEP_W-1){1'b0}}, head_job.pre_bar};
    assign sym_phase = !bar_phase && (sym_k < head_job.n_sym);
    assign bit_idx   = head_job.n_sym - 3'd1 - sym_k;

    always_comb
    begin
        priority if (bar_phase)
        begin
            cur_char = CH_BAR;
        end
        else if (sym_phase)
        begin
            cur_char = head_job.pat[bit_idx] ? CH_DASH : CH_DOT;
        end
        else
        begin
            cur_char = head_job.tail;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        step_next      = step_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_char_next = cur_char;
                out_last_next = !bar_phase && !sym_phase;
                if (!bar_phase && !sym_phase)
                begin
                    pop       = 1'b1;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== hw/rtl/morse_code_translator_unit.sv =====
// The first result beat of an item passes through the job queue, then the registered output.
// Throughput: one result beat per cycle while jobs wait and result ready is high; an item
// gives 1 to 6 beats, and items giving no beat cost nothing in the back end. Input is taken every
// cycle while the job queue has room. Reset (rst_n low, asynchronous) selects encode,
// clears the open token, empties the queue and drops result valid.
module morse_code_translator_unit #(
    parameter int QUEUE_DEPTH = mct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    mct_in_if.sink    item,
    mct_out_if.source result
);
    import mct_pkg::*;

    // front -> queue
    logic push;
    job_t push_job;
    logic q_full;

    // queue -> back
    logic head_valid;
    job_t head_job;
    logic pop;

    // Front end: holds the direction bit and the decode token, turns each
    // item beat into at most one job (bar, symbols, tail character).
    mct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // Short job queue so the front keeps taking beats while a job drains.
    mct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: steps through the head job, one character per beat, into a
    // registered output; pops the job on its tail character (flagged last).
    mct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== hw/rtl/mct_checker.sv =====
module mct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] out_char,
    input logic       last
);
    import mct_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_char) && $stable(last))
        else $error("result beat changed while stalled");

    // only dots, dashes and bars come before the end of an item's results
    a_mid_chars: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> out_char == CH_DOT || out_char == CH_DASH
                                  || out_char == CH_BAR)
        else $error("unexpected character inside a result group");

    // code symbols never close a group
    a_sym_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_char == CH_DOT || out_char == CH_DASH) |-> !last)
        else $error("symbol flagged last");

    // taken bar is followed at once by its space
    a_bar_space: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && out_char == CH_BAR
        |=> result_valid && out_char == CH_SPACE && last)
        else $error("bar not followed by space");

endmodule

bind morse_code_translator_unit mct_checker u_mct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_char     (result.out_char),
    .last         (result.last)
);

// ===== tb/morse_translation_check.sv =====
module morse_translation_check (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_data,
    mct_in_if    item_mon,
    mct_out_if   result_mon,
    output int   errors,
    output int   pending
);
    import mct_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_beat_t;

    out_beat_t         due_beats [$];
    logic [CHAR_W-1:0] step_chars [$];

    logic             dir;
    logic [PAT_W-1:0] tok_pat;
    logic [LEN_W-1:0] tok_len;
    logic             tok_bad;
    logic             tok_bar;

    // heap-ordered code tree: '.' goes i -> 2i+1, '-' goes i -> 2i+2, '_' = no char
    function automatic logic [CHAR_W-1:0] tree_char(input int idx);
        string             tree;
        logic [CHAR_W-1:0] c;
        tree = "_ETIANMSURWDKGOHVF_L_PJBXCYZQ__54_3___2_______16_______7___8_90";
        c = tree[idx];
        return (c == "_") ? CH_NONE : c;
    endfunction

    // append one character to this step's output
    function void add_char(input logic [CHAR_W-1:0] c);
        step_chars = {step_chars, c};
    endfunction

    function void clear_token();
        tok_pat = '0;
        tok_len = '0;
        tok_bad = 1'b0;
        tok_bar = 1'b0;
    endfunction

    function void encode_char(input logic [SYMBOL_W-1:0] sym);
        int hit;
        int len;
        int pat;
        hit = 0;
        if (sym == CH_SPACE) begin
            add_char(CH_BAR);
        end
        else if ((sym >= "A" && sym <= "Z") || (sym >= "0" && sym <= "9")) begin
            for (int i = 1; i < 63; i++)
                if (tree_char(i) == sym)
                    hit = i;
            len = 0;
            while ((1 << (len + 1)) <= hit + 1)
                len++;
            pat = hit + 1 - (1 << len);
            for (int k = len; k > 0; k--)
                add_char(((pat >> (k - 1)) & 1) ? CH_DASH : CH_DOT);
        end
        add_char(CH_SPACE);
    endfunction

    function void flush_token();
        int idx;
        if (!tok_bad) begin
            if (tok_bar) begin
                add_char(CH_SPACE);
            end
            else if (tok_len >= 1 && tok_len <= LEN_MAX) begin
                idx = (1 << tok_len) - 1 + tok_pat;
                if (tree_char(idx) != CH_NONE)
                    add_char(tree_char(idx));
            end
        end
        clear_token();
    endfunction

    function void collect_char(input logic [SYMBOL_W-1:0] sym);
        if (sym == CH_BAR) begin
            if (tok_len == 0 && !tok_bad && !tok_bar) begin
                tok_bar = 1'b1;
            end
            else begin
                tok_bad = 1'b1;
                tok_bar = 1'b0;
            end
        end
        else if (sym == CH_DOT || sym == CH_DASH) begin
            if (tok_bar) begin
                tok_bad = 1'b1;
                tok_bar = 1'b0;
            end
            if (tok_len < LEN_MAX) begin
                tok_pat = {tok_pat[PAT_W-2:0], sym == CH_DASH};
                tok_len = tok_len + 1'b1;
            end
            else begin
                tok_len = LEN_TOO_LONG;
            end
        end
        else begin
            tok_bad = 1'b1;
            tok_bar = 1'b0;
        end
    endfunction

    function void predict_translation(input logic [SYMBOL_W-1:0] sym, input logic le);
        out_beat_t beat;
        step_chars.delete();
        if (dir == DIR_ENCODE) begin
            if (le)
                clear_token();
            else
                encode_char(sym);
        end
        else if (le || sym == CH_SPACE) begin
            flush_token();
        end
        else begin
            collect_char(sym);
        end
        foreach (step_chars[i]) begin
            beat.ch   = step_chars[i];
            beat.last = (i == step_chars.size() - 1);
            due_beats = {due_beats, beat};
        end
    endfunction

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin : watch
        out_beat_t want;
        if (!rst_n) begin
            dir = DIR_ENCODE;
            clear_token();
            due_beats.delete();
            pending = 0;
        end
        else begin
            if (cfg_we)
                dir = cfg_data;
            if (item_mon.valid && item_mon.ready)
                predict_translation(item_mon.symbol, item_mon.line_end);
            if (result_mon.valid && result_mon.ready) begin
                if (due_beats.size() == 0) begin
                    $display("%0t: beat with none due: expected none, got out_char %h last %b",
                             $time, result_mon.out_char, result_mon.last);
                    errors++;
                end
                else begin
                    want = due_beats.pop_front();
                    if (result_mon.out_char !== want.ch) begin
                        $display("%0t: out_char expected %h, got %h",
                                 $time, want.ch, result_mon.out_char);
                        errors++;
                    end
                    if (result_mon.last !== want.last) begin
                        $display("%0t: last expected %b, got %b",
                                 $time, want.last, result_mon.last);
                        errors++;
                    end
                end
            end
            pending = due_beats.size();
        end
    end

endmodule

// ===== tb/tb_morse_code_translator_unit.sv =====
module tb_morse_code_translator_unit;
    import mct_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES       = 8;
    // cap on the length of the whole run, set with ample headroom
    localparam int CYCLE_LIMIT  = 400000;
    // a step with no result may still be in flight when the last due beat lands
    localparam int DRAIN_CYCLES = 10;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    mct_in_if  item ();
    mct_out_if result ();

    int err_count;
    int beats_due;
    int cycles = 0;
    int sent = 0;
    bit src_idles;
    bit sink_idles;

    morse_code_translator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .result   (result)
    );

    // watches both channels, runs its own model of the translator and scores the beats
    morse_translation_check chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_mon   (item),
        .result_mon (result),
        .errors     (err_count),
        .pending    (beats_due)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: also catches beats that never arrive
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_morse_code_translator_unit: done, errors");
            $finish;
        end
    end

    // one input beat; the gap before it is drawn fresh for every item.
    // Returns at the edge that took the beat, with valid still high, so a
    // back-to-back item only ever reassigns valid once per step.
    task automatic send_item(input logic [SYMBOL_W-1:0] sym, input logic le);
        int gap;
        gap = src_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid    <= 1'b1;
        item.symbol   <= sym;
        item.line_end <= le;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_line_end();
        // symbol is don't-care here, so let it roam
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_mark();
        return $urandom_range(0, 1) ? CH_DASH : CH_DOT;
    endfunction

    // drop valid, let every due beat land, then leave room for a silent step
    task automatic wait_idle();
        item.valid <= 1'b0;
        @(negedge clk);
        while (beats_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // encode mode: mostly table characters and word gaps, some stray bytes and line ends
    task automatic encode_item();
        string plain;
        int    pick;
        plain = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ";
        pick  = $urandom_range(0, 19);
        if (pick < 14)
            send_item(plain[$urandom_range(0, plain.len() - 1)], 1'b0);
        else if (pick < 18)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        else
            send_line_end();
    endtask

    // decode mode: one token and its terminator. Mostly well-formed codes of
    // 1 to 5 marks (some land on shapes with no character), then over-long
    // tokens, word bars, bars mixed with marks, stray bytes and empty tokens.
    task automatic decode_token();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        n    = 0;
        if (kind < 12)
            n = $urandom_range(1, 5);
        else if (kind < 14)
            n = $urandom_range(6, 8);
        for (int i = 0; i < n; i++)
            send_item(pick_mark(), 1'b0);
        case (kind)
            14: send_item(CH_BAR, 1'b0);
            15:
            begin
                send_item(pick_mark(), 1'b0);
                send_item(CH_BAR, 1'b0);
            end
            16:
            begin
                send_item(CH_BAR, 1'b0);
                send_item($urandom_range(0, 2) == 0 ? CH_BAR : pick_mark(), 1'b0);
            end
            17:
            begin
                send_item(pick_mark(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item(pick_mark(), 1'b0);
            end
            19: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: ;
        endcase
        // kind 18 falls through to here alone: an empty token
        if ($urandom_range(0, 5) == 0)
            send_line_end();
        else
            send_item(CH_SPACE, 1'b0);
    endtask

    // result side: fresh stall per beat, ready held high while a beat is awaited
    initial
    begin : result_sink
        int stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = sink_idles ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int goal;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= DIR_ENCODE;
        item.valid    <= 1'b0;
        item.symbol   <= '0;
        item.line_end <= 1'b0;
        src_idles  = 1'b1;
        sink_idles = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode: table ends, word gap, lowercase, top byte, line end
        set_direction(DIR_ENCODE);
        send_str("A0Z9 a");
        send_item(8'hFF, 1'b0);
        send_line_end();

        // decode: longest code closed by a line end, bar token, empty token,
        // a shape with no character, bar mixed with a mark
        set_direction(DIR_DECODE);
        send_str("-----");
        send_line_end();
        send_str("| ");
        send_str(" ");
        send_str("..-- ");
        send_str(".|");
        send_line_end();

        // a half-built token must come through a trip to encode mode untouched
        send_str("-");
        set_direction(DIR_ENCODE);
        send_str("E");
        set_direction(DIR_DECODE);
        send_str(" ");

        // random phases, alternating direction
        for (int p = 0; p < PHASES; p++)
        begin
            set_direction((p % 2 == 1) ? DIR_ENCODE : DIR_DECODE);
            goal = sent + RANDOM_ITEMS / PHASES;
            while (sent < goal)
            begin
                // switch idling on and off in stretches, each side on its own
                if ($urandom_range(0, 15) == 0)
                begin
                    src_idles  = ($urandom_range(0, 2) != 0);
                    sink_idles = ($urandom_range(0, 2) != 0);
                end
                if (p % 2 == 1)
                    encode_item();
                else
                    decode_token();
            end
            // sometimes leave a token open across the switch
            if (p % 2 == 0 && $urandom_range(0, 1) == 1)
                send_item(pick_mark(), 1'b0);
        end

        wait_idle();
        if (err_count == 0)
            $display("tb_morse_code_translator_unit: done, clean");
        else
            $display("tb_morse_code_translator_unit: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mct_pkg.sv
hw/rtl/mct_in_if.sv
hw/rtl/mct_out_if.sv
hw/rtl/mct_front.sv
hw/rtl/mct_queue.sv
hw/rtl/mct_back.sv
hw/rtl/morse_code_translator_unit.sv
hw/rtl/mct_checker.sv
tb/morse_translation_check.sv
tb/tb_morse_code_translator_unit.sv
